// File: src/bss_pkg.sv
// Shared types and constants for the bright spike soften 3x3 filter.
// Depends on nothing; the interfaces, the divider and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

   // Field and register widths fixed by the interface.
   localparam int AO_W     = 16;
   localparam int FW_W     = 6;
   localparam int FH_W     = 12;
   localparam int GAP_W    = 16;
   localparam int SOFT_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_GAP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTEN_AMOUNT = 2'd3;

   // Register reset values.
   localparam logic [FW_W-1:0]   FRAME_WIDTH_RST   = 6'd32;
   localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST  = 12'd32;
   localparam logic [GAP_W-1:0]  SPIKE_GAP_RST     = 16'd5898;
   localparam logic [SOFT_W-1:0] SOFTEN_AMOUNT_RST = 16'd11469;

   // A flush emits one row plus one pixel, so the row is capped to keep it under 64.
   localparam int FLUSH_WIDTH_LIMIT = 62;

   // Q1.15 unity for the soften factor.
   localparam logic [SOFT_W-1:0] SOFT_ONE = 16'd32768;
   localparam int SOFT_SHIFT = 15;

   // Neighbourhood count (at most nine) and the divisor 2 * count.
   localparam int CNT_W = 4;
   localparam int DEN_W = 5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LAST,
      S_MULT,
      S_DECIDE,
      S_DIV,
      S_SCALE,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// File: src/bss_if.sv
// Valid/ready channel interfaces for the request and response sides of the filter.
// Depends on bss_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface bss_req_if;
   logic                     valid;
   logic                     ready;
   logic [bss_pkg::AO_W-1:0] ao_value;

   modport source (output valid, output ao_value, input ready);
   modport sink   (input valid, input ao_value, output ready);
endinterface

interface bss_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [bss_pkg::AO_W-1:0] filtered_value;
   logic                     last_of_run;
   logic                     frame_done;

   modport source (output valid, output filtered_value, output last_of_run,
                   output frame_done, input ready);
   modport sink   (input valid, input filtered_value, input last_of_run,
                   input frame_done, output ready);
endinterface

`default_nettype wire

// File: src/bss_line_store.sv
// Three-row line store: one write port and one read port with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module bss_line_store #(
   parameter  int MAX_WIDTH  = 32,
   parameter  int VALUE_BITS = 16,
   localparam int DEPTH      = 3 * MAX_WIDTH,
   localparam int ADDR_W     = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [VALUE_BITS-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output logic      [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] mem_ff [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/bss_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on bss_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module bss_divider #(
   parameter  int NUM_W = 21,
   parameter  int DEN_W = 5,
   localparam int CNT_W = $clog2(NUM_W + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [NUM_W-1:0]       num,
   input  wire logic [DEN_W-1:0]       den,
   output logic      [NUM_W-1:0]       quot,
   output bss_pkg::div_status_type     status
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, acc_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         acc_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         acc_in = {acc_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot        = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// File: src/bright_spike_soften_3x3.sv
// Top level of the 3x3 bright spike soften filter: registers, sequencer, arithmetic.
// Depends on bss_pkg, bss_if, bss_line_store and bss_divider.
//
// Usage: occlusion samples (Q1.15) arrive on req_chan in row order, one transfer per
// pixel. Each transfer is written into a three-row line store. Results leave on rsp_chan
// one row plus one pixel behind the input; the transfer of a frame's last pixel flushes
// every remaining result, and frame_done marks the frame's final pixel. last_of_run marks
// the final result caused by one request transfer.
// The csr_ port writes frame_width, frame_height, spike_gap and soften_amount by index;
// writing either geometry register restarts the frame. Write it only while idle.
// A filtered pixel issues its nine neighbour reads on the single line store read port,
// then goes through accumulation, multiply and decision, and then loads the output register.
// An outlier adds the bit-serial divider and a scaling step before the output. A request is
// accepted only in idle, so the block takes no new sample before the last one's results
// are loaded; a flush produces its results one after another.
// With width or height below 2 the block passes samples through, one per cycle while the receiver accepts them.
// Reset (synchronous, active high) restores the register defaults and clears the position
// counters; the line store is not cleared and is only read where written this frame.
// A stalled receiver holds the result in the output register; the sequencer waits for it
// to drain before loading the next result, and new requests wait in idle.
`timescale 1ns / 1ps
`default_nettype none

module bright_spike_soften_3x3 #(
   parameter int MAX_WIDTH  = 32,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bss_req_if.sink                                req_chan,
   bss_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [bss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bss_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int VB     = VALUE_BITS;
   localparam int ADDR_W = $clog2(3 * MAX_WIDTH);
   localparam int SUM_W  = VB + bss_pkg::CNT_W;
   localparam int NUM_W  = VB + bss_pkg::CNT_W + 1;
   localparam int PROD_W = VB + bss_pkg::SOFT_W;
   localparam int CMP_W  = (VB > bss_pkg::GAP_W) ? VB : bss_pkg::GAP_W;
   localparam int WCAP   = (MAX_WIDTH < bss_pkg::FLUSH_WIDTH_LIMIT) ? MAX_WIDTH
                                                                   : bss_pkg::FLUSH_WIDTH_LIMIT;
   localparam int FW  = bss_pkg::FW_W;
   localparam int FH  = bss_pkg::FH_W;
   localparam int CW  = bss_pkg::CNT_W;

   // Configuration registers.
   logic [FW-1:0]                 frame_width_ff;
   logic [FH-1:0]                 frame_height_ff;
   logic [bss_pkg::GAP_W-1:0]     spike_gap_ff;
   logic [bss_pkg::SOFT_W-1:0]    soften_ff;
   logic                          geom_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bss_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= bss_pkg::FRAME_HEIGHT_RST;
         spike_gap_ff    <= bss_pkg::SPIKE_GAP_RST;
         soften_ff       <= bss_pkg::SOFTEN_AMOUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bss_pkg::CSR_FRAME_WIDTH:   frame_width_ff  <= csr_wdata[FW-1:0];
            bss_pkg::CSR_FRAME_HEIGHT:  frame_height_ff <= csr_wdata[FH-1:0];
            bss_pkg::CSR_SPIKE_GAP:     spike_gap_ff    <= csr_wdata;
            bss_pkg::CSR_SOFTEN_AMOUNT: soften_ff       <= csr_wdata;
         endcase
      end
   end

   assign geom_write = csr_we && (csr_index == bss_pkg::CSR_FRAME_WIDTH ||
                                  csr_index == bss_pkg::CSR_FRAME_HEIGHT);

   // Derived geometry.
   logic [FW-1:0]              eff_w;
   logic [FH-1:0]              eff_h;
   logic                       small_frame;
   logic [FW-1:0]              pass_w;
   logic [FH-1:0]              pass_h;
   logic [bss_pkg::SOFT_W-1:0] soft_sat;

   assign eff_w       = (frame_width_ff > FW'(WCAP)) ? FW'(WCAP) : frame_width_ff;
   assign eff_h       = frame_height_ff;
   assign small_frame = (eff_w < FW'(2)) || (eff_h < FH'(2));
   assign pass_w      = (eff_w == '0) ? FW'(1) : eff_w;
   assign pass_h      = (eff_h == '0) ? FH'(1) : eff_h;
   assign soft_sat    = (soften_ff > bss_pkg::SOFT_ONE) ? bss_pkg::SOFT_ONE : soften_ff;

   // Sequencer and position state.
   bss_pkg::state_type state_ff, state_in;
   logic          flush_ff, flush_in;
   logic [FW-1:0] in_col_ff, in_col_in;
   logic [FH-1:0] in_row_ff, in_row_in;
   logic [1:0]    in_ph_ff, in_ph_in;
   logic [FW-1:0] out_col_ff, out_col_in;
   logic [FH-1:0] out_row_ff, out_row_in;
   logic [1:0]    out_ph_ff, out_ph_in;
   logic [1:0]    sr_ff, sr_in;
   logic [1:0]    sc_ff, sc_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_center_ff, rd_center_in;

   // Accumulators and arithmetic.
   logic [SUM_W-1:0]  sum_ff;
   logic [CW-1:0]     cnt_ff;
   logic [VB-1:0]     dark_ff;
   logic [VB-1:0]     center_ff;
   logic [SUM_W-1:0]  cc_ff;
   logic [SUM_W-1:0]  dc_ff;
   logic              spike_ff, spike_in;
   logic [PROD_W-1:0] prod_ff;
   logic              acc_clear;

   // Output register.
   logic                     rsp_valid_ff;
   logic [bss_pkg::AO_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_done_ff, rsp_done_in;
   logic                     rsp_load;
   logic                     out_free;

   // Line store ports.
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [VB-1:0]     mem_rd_data;

   // Divider ports.
   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic [bss_pkg::DEN_W-1:0] div_den;
   logic [NUM_W-1:0]        div_quot;
   bss_pkg::div_status_type div_stat;

   // Working signals of the sequencer.
   logic          req_xfer;
   logic [VB-1:0] in_value;
   logic          restart;
   logic [FW-1:0] pos_col;
   logic [FH-1:0] pos_row;
   logic [1:0]    pos_ph;
   logic          in_is_last;
   logic          emit_one;
   logic [FW-1:0] sm_col;
   logic [FH-1:0] sm_row;
   logic          sm_last;
   logic          row_ok;
   logic          col_ok;
   logic [1:0]    rd_ph;
   logic [FW-1:0] rd_col;
   logic          out_fin;
   logic [VB-1:0] target;
   logic [VB-1:0] result;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == bss_pkg::S_IDLE) && (!small_frame || out_free);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign in_value       = VB'(req_chan.ao_value);

   assign target  = VB'(div_quot);
   assign result  = spike_ff ? VB'(center_ff - VB'(prod_ff >> bss_pkg::SOFT_SHIFT)) : center_ff;
   assign out_fin = (out_row_ff == eff_h - FH'(1)) && (out_col_ff == eff_w - FW'(1));

   // Neighbour address of the current read slot, and whether the slot lies in the frame.
   always_comb begin
      unique case (sr_ff)
         2'd0:    begin
            row_ok = out_row_ff != '0;
            rd_ph  = (out_ph_ff == 2'd0) ? 2'd2 : 2'(out_ph_ff - 2'd1);
         end
         2'd2:    begin
            row_ok = out_row_ff != eff_h - FH'(1);
            rd_ph  = (out_ph_ff == 2'd2) ? 2'd0 : 2'(out_ph_ff + 2'd1);
         end
         default: begin
            row_ok = 1'b1;
            rd_ph  = out_ph_ff;
         end
      endcase
      unique case (sc_ff)
         2'd0:    begin
            col_ok = out_col_ff != '0;
            rd_col = FW'(out_col_ff - FW'(1));
         end
         2'd2:    begin
            col_ok = out_col_ff != eff_w - FW'(1);
            rd_col = FW'(out_col_ff + FW'(1));
         end
         default: begin
            col_ok = 1'b1;
            rd_col = out_col_ff;
         end
      endcase
   end

   assign mem_rd_addr = ADDR_W'(ADDR_W'(rd_ph) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col));
   assign mem_wr_addr = ADDR_W'(ADDR_W'(pos_ph) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pos_col));

   // Input position after the restart check of a normal frame, and the pass-through position.
   always_comb begin
      restart    = (in_col_ff >= eff_w) || (in_row_ff >= eff_h);
      pos_col    = restart ? '0 : in_col_ff;
      pos_row    = restart ? '0 : in_row_ff;
      pos_ph     = restart ? '0 : in_ph_ff;
      in_is_last = (pos_col == eff_w - FW'(1)) && (pos_row == eff_h - FH'(1));
      emit_one   = (pos_row >= FH'(2)) || ((pos_row == FH'(1)) && (pos_col >= FW'(1)));
      sm_col     = (in_col_ff >= pass_w) ? '0 : in_col_ff;
      sm_row     = (in_row_ff >= pass_h) ? '0 : in_row_ff;
      sm_last    = (sm_col == pass_w - FW'(1)) && (sm_row == pass_h - FH'(1));
   end

   // Next state and outputs of the sequencer.
   always_comb begin
      state_in     = state_ff;
      flush_in     = flush_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_ph_in     = in_ph_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_ph_in    = out_ph_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      rd_pend_in   = 1'b0;
      rd_center_in = 1'b0;
      spike_in     = spike_ff;
      acc_clear    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         bss_pkg::S_IDLE: begin
            if (req_xfer && small_frame) begin
               // Pass-through frame: one result per transfer, straight out.
               rsp_load     = 1'b1;
               rsp_value_in = bss_pkg::AO_W'(in_value);
               rsp_last_in  = 1'b1;
               rsp_done_in  = sm_last;
               if (FW'(sm_col + FW'(1)) >= pass_w) begin
                  in_col_in = '0;
                  in_row_in = (FH'(sm_row + FH'(1)) >= pass_h) ? '0 : FH'(sm_row + FH'(1));
               end else begin
                  in_col_in = FW'(sm_col + FW'(1));
                  in_row_in = sm_row;
               end
               in_ph_in   = '0;
               out_col_in = '0;
               out_row_in = '0;
               out_ph_in  = '0;
            end else if (req_xfer) begin
               mem_wr_en = 1'b1;
               if (restart) begin
                  out_col_in = '0;
                  out_row_in = '0;
                  out_ph_in  = '0;
               end
               sr_in     = '0;
               sc_in     = '0;
               acc_clear = 1'b1;
               if (in_is_last) begin
                  // The frame's last pixel: flush everything still pending.
                  flush_in  = 1'b1;
                  state_in  = bss_pkg::S_READ;
                  in_col_in = '0;
                  in_row_in = '0;
                  in_ph_in  = '0;
               end else begin
                  flush_in = 1'b0;
                  if (emit_one) begin
                     state_in = bss_pkg::S_READ;
                  end
                  if (pos_col == eff_w - FW'(1)) begin
                     in_col_in = '0;
                     in_row_in = FH'(pos_row + FH'(1));
                     in_ph_in  = (pos_ph == 2'd2) ? 2'd0 : 2'(pos_ph + 2'd1);
                  end else begin
                     in_col_in = FW'(pos_col + FW'(1));
                     in_row_in = pos_row;
                     in_ph_in  = pos_ph;
                  end
               end
            end
         end
         bss_pkg::S_READ: begin
            mem_rd_en    = row_ok && col_ok;
            rd_pend_in   = row_ok && col_ok;
            rd_center_in = (sr_ff == 2'd1) && (sc_ff == 2'd1);
            if (sc_ff == 2'd2) begin
               sc_in = '0;
               sr_in = 2'(sr_ff + 2'd1);
               if (sr_ff == 2'd2) begin
                  state_in = bss_pkg::S_LAST;
               end
            end else begin
               sc_in = 2'(sc_ff + 2'd1);
            end
         end
         bss_pkg::S_LAST: begin
            state_in = bss_pkg::S_MULT;
         end
         bss_pkg::S_MULT: begin
            state_in = bss_pkg::S_DECIDE;
         end
         bss_pkg::S_DECIDE: begin
            spike_in = (soft_sat != '0) &&
                       (CMP_W'(VB'(center_ff - dark_ff)) > CMP_W'(spike_gap_ff)) &&
                       (cc_ff > sum_ff);
            if (spike_in) begin
               div_start = 1'b1;
               state_in  = bss_pkg::S_DIV;
            end else begin
               state_in = bss_pkg::S_EMIT;
            end
         end
         bss_pkg::S_DIV: begin
            if (div_stat.done) begin
               state_in = bss_pkg::S_SCALE;
            end
         end
         bss_pkg::S_SCALE: begin
            state_in = bss_pkg::S_EMIT;
         end
         bss_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = bss_pkg::AO_W'(result);
               rsp_last_in  = flush_ff ? out_fin : 1'b1;
               rsp_done_in  = flush_ff && out_fin;
               if (out_col_ff == eff_w - FW'(1)) begin
                  out_col_in = '0;
                  out_row_in = FH'(out_row_ff + FH'(1));
                  out_ph_in  = (out_ph_ff == 2'd2) ? 2'd0 : 2'(out_ph_ff + 2'd1);
               end else begin
                  out_col_in = FW'(out_col_ff + FW'(1));
               end
               if (flush_ff && !out_fin) begin
                  state_in  = bss_pkg::S_READ;
                  sr_in     = '0;
                  sc_in     = '0;
                  acc_clear = 1'b1;
               end else begin
                  state_in = bss_pkg::S_IDLE;
                  if (flush_ff) begin
                     out_col_in = '0;
                     out_row_in = '0;
                     out_ph_in  = '0;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || geom_write) begin
         state_ff   <= bss_pkg::S_IDLE;
         flush_ff   <= 1'b0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_ph_ff   <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_ph_ff  <= '0;
         sr_ff      <= '0;
         sc_ff      <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         flush_ff   <= flush_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_ph_ff   <= in_ph_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_ph_ff  <= out_ph_in;
         sr_ff      <= sr_in;
         sc_ff      <= sc_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // Window accumulation, centre products and scaling: read data arrives in the cycle after its slot was issued.
   always_ff @(posedge clock) begin
      rd_center_ff <= rd_center_in;
      spike_ff     <= spike_in;
      if (acc_clear) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         dark_ff <= '1;
      end else if (rd_pend_ff) begin
         sum_ff  <= SUM_W'(sum_ff + SUM_W'(mem_rd_data));
         cnt_ff  <= CW'(cnt_ff + CW'(1));
         dark_ff <= (mem_rd_data < dark_ff) ? mem_rd_data : dark_ff;
      end
      if (rd_pend_ff && rd_center_ff) begin
         center_ff <= mem_rd_data;
      end
      if (state_ff == bss_pkg::S_MULT) begin
         cc_ff <= SUM_W'(center_ff * cnt_ff);
         dc_ff <= SUM_W'(dark_ff * cnt_ff);
      end
      if (state_ff == bss_pkg::S_SCALE) begin
         prod_ff <= PROD_W'(VB'(center_ff - target) * soft_sat);
      end
   end

   assign div_num = NUM_W'(sum_ff) + NUM_W'(dc_ff);
   assign div_den = {cnt_ff, 1'b0};

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_value = rsp_value_ff;
   assign rsp_chan.last_of_run    = rsp_last_ff;
   assign rsp_chan.frame_done     = rsp_done_ff;

   bss_line_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (in_value),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bss_divider #(
      .NUM_W (NUM_W),
      .DEN_W (bss_pkg::DEN_W)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quot   (div_quot),
      .status (div_stat)
   );

   // The line store never sees a write and a read in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(mem_wr_en && mem_rd_en))
      else $error("line store written and read in one cycle");

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == bss_pkg::S_DIV)
      else $error("divider finished outside its wait state");

   // A new result only appears after an idle pass-through or an emit step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == bss_pkg::S_IDLE ||
                               $past(state_ff) == bss_pkg::S_EMIT))
      else $error("result loaded from an unexpected state");

   // Request transfers are taken only while the sequencer is idle and the divider is not busy.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (state_ff == bss_pkg::S_IDLE) && !div_stat.busy)
      else $error("request accepted while a pixel is in progress");

endmodule

`default_nettype wire
